/* hw/rtl/kmc_pkg.sv */
// ----------------------------------------------------------------------------
// kmc_pkg
// Types and constants shared by the k-mer mismatch counter and its channels.
// ----------------------------------------------------------------------------
package kmc_pkg;

  // Field widths of the channels
  localparam int KMER_W  = 64;
  localparam int COUNT_W = 6;

  // Configuration port
  localparam int LEN_W       = 6;
  localparam int BASE_W      = 5;
  localparam int CFG_DATA_W  = 6;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_KMER_LENGTH   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET_BASE = 1'b1;

  localparam logic [LEN_W-1:0]  KMER_LENGTH_RST   = 6'd4;
  localparam logic [BASE_W-1:0] ALPHABET_BASE_RST = 5'd4;
  localparam logic [BASE_W-1:0] BASE_MIN          = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX          = 5'd16;

  // Divider: dividend bits consumed per cycle, remainder width (base <= 16)
  localparam int STEP_BITS = 8;
  localparam int REM_W     = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_CHECK,
    ST_DIGIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [STEP_BITS-1:0] quo;
  } div_res_t;

  // Restoring division of one chunk of dividend bits by a small base
  function automatic div_res_t div_chunk(input logic [BASE_W-1:0] base,
                                         input logic [REM_W-1:0] rem_in,
                                         input logic [STEP_BITS-1:0] bits);
    div_res_t         res;
    logic [BASE_W-1:0] trial;
    logic [REM_W-1:0]  rem;
    rem = rem_in;
    res.quo = '0;
    for (int j = STEP_BITS - 1; j >= 0; j--) begin
      trial = {rem, bits[j]};
      if (trial >= base) begin
        res.quo[j] = 1'b1;
        rem = REM_W'(trial - base);
      end else begin
        rem = trial[REM_W-1:0];
      end
    end
    res.rem = rem;
    return res;
  endfunction

endpackage

/* hw/rtl/kmc_if.sv */
// ----------------------------------------------------------------------------
// kmc_if
// Valid/ready channels carrying k-mer pairs in and mismatch counts out.
// ----------------------------------------------------------------------------
interface kmc_in_if;
  logic                       valid;
  logic                       ready;
  logic [kmc_pkg::KMER_W-1:0] first_kmer;
  logic [kmc_pkg::KMER_W-1:0] second_kmer;

  modport source (output valid, output first_kmer, output second_kmer, input ready);
  modport sink   (input valid, input first_kmer, input second_kmer, output ready);
endinterface

interface kmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [kmc_pkg::COUNT_W-1:0] mismatch_count;
  logic                        range_error;

  modport source (output valid, output mismatch_count, output range_error, input ready);
  modport sink   (input valid, input mismatch_count, input range_error, output ready);
endinterface

/* hw/rtl/kmer_mismatch_count_top.sv */
// ----------------------------------------------------------------------------
// kmer_mismatch_count_top
// Hamming distance between two k-mers written as base-n digit strings.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+---------------------------------------
//  query     | in  | valid/ready  | first_kmer[63:0], second_kmer[63:0]
//  result    | out | valid/ready  | mismatch_count[5:0], range_error
//  cfg       | in  | cfg_we only  | cfg_index (0 length, 1 base), cfg_data
//
//  The base^k loop (k = effective length) stops early once the power overflows,
//  and a range error skips the digit phase, where a restoring divider per k-mer
//  retires 8 bits per cycle. The next item is taken once the sequencer is back
//  in idle, even while the result waits; reset is synchronous, no clearing pass;
//  completion holds until the output is free.
// ----------------------------------------------------------------------------
module kmer_mismatch_count_top #(
  parameter int MAX_DIGITS = 32,
  parameter int VALUE_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [kmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [kmc_pkg::CFG_DATA_W-1:0]      cfg_data,
  kmc_in_if.sink                              query,
  kmc_out_if.source                           result
);
  import kmc_pkg::*;

  localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PADW       = DIV_CYCLES * STEP_BITS;
  localparam int SUB_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int PROD_W     = KMER_W + BASE_W;

  // Configuration registers
  logic [LEN_W-1:0]  kmer_length;
  logic [BASE_W-1:0] alphabet_base;

  // Sequencer and datapath registers
  state_t             state, state_next;
  logic [KMER_W-1:0]  limit, limit_next;
  logic               huge, huge_next;
  logic               wide, wide_next;
  logic               err, err_next;
  logic [LEN_W-1:0]   cnt, cnt_next;
  logic [SUB_W-1:0]   sub, sub_next;
  logic [PADW-1:0]    dividend_a, dividend_a_next;
  logic [PADW-1:0]    dividend_c, dividend_c_next;
  logic [REM_W-1:0]   rem_a, rem_a_next;
  logic [REM_W-1:0]   rem_c, rem_c_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               out_valid, out_valid_next;
  logic [COUNT_W-1:0] out_count, out_count_next;
  logic               out_err, out_err_next;

  logic [LEN_W-1:0]   k_eff;
  logic [BASE_W-1:0]  b_eff;
  logic [PROD_W-1:0]  product;
  div_res_t           chunk_a, chunk_c;

  // Clamp the configured length and base into their working ranges
  always_comb begin
    priority if (kmer_length == '0) begin
      k_eff = LEN_W'(1);
    end else if (kmer_length > LEN_W'(MAX_DIGITS)) begin
      k_eff = LEN_W'(MAX_DIGITS);
    end else begin
      k_eff = kmer_length;
    end
    priority if (alphabet_base < BASE_MIN) begin
      b_eff = BASE_MIN;
    end else if (alphabet_base > BASE_MAX) begin
      b_eff = BASE_MAX;
    end else begin
      b_eff = alphabet_base;
    end
  end

  // Shared arithmetic: one limit multiply, one divide chunk per k-mer
  assign product = PROD_W'(limit) * PROD_W'(b_eff);
  assign chunk_a = div_chunk(b_eff, rem_a, dividend_a[PADW-1 -: STEP_BITS]);
  assign chunk_c = div_chunk(b_eff, rem_c, dividend_c[PADW-1 -: STEP_BITS]);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length   <= KMER_LENGTH_RST;
      alphabet_base <= ALPHABET_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KMER_LENGTH:   kmer_length   <= cfg_data[LEN_W-1:0];
        CFG_ALPHABET_BASE: alphabet_base <= cfg_data[BASE_W-1:0];
      endcase
    end
  end

  // State register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    limit      <= limit_next;
    huge       <= huge_next;
    wide       <= wide_next;
    err        <= err_next;
    cnt        <= cnt_next;
    sub        <= sub_next;
    dividend_a <= dividend_a_next;
    dividend_c <= dividend_c_next;
    rem_a      <= rem_a_next;
    rem_c      <= rem_c_next;
    count      <= count_next;
    out_count  <= out_count_next;
    out_err    <= out_err_next;
  end

  // Next state and outputs
  always_comb begin
    state_next      = state;
    limit_next      = limit;
    huge_next       = huge;
    wide_next       = wide;
    err_next        = err;
    cnt_next        = cnt;
    sub_next        = sub;
    dividend_a_next = dividend_a;
    dividend_c_next = dividend_c;
    rem_a_next      = rem_a;
    rem_c_next      = rem_c;
    count_next      = count;
    out_count_next  = out_count;
    out_err_next    = out_err;
    out_valid_next  = out_valid && !result.ready;
    query.ready     = (state == ST_IDLE);

    unique case (state)
      // Take an item and prime the limit loop
      ST_IDLE: begin
        if (query.valid) begin
          dividend_a_next = PADW'(query.first_kmer[VALUE_BITS-1:0]);
          dividend_c_next = PADW'(query.second_kmer[VALUE_BITS-1:0]);
          wide_next  = ((query.first_kmer >> VALUE_BITS) != '0) ||
                       ((query.second_kmer >> VALUE_BITS) != '0);
          limit_next = KMER_W'(1);
          huge_next  = 1'b0;
          cnt_next   = '0;
          count_next = '0;
          state_next = ST_LIMIT;
        end
      end
      // Build base^k, stop early once it no longer fits
      ST_LIMIT: begin
        if (product[PROD_W-1:KMER_W] != '0) begin
          huge_next  = 1'b1;
          state_next = ST_CHECK;
        end else begin
          limit_next = product[KMER_W-1:0];
          if (cnt == k_eff - LEN_W'(1)) begin
            state_next = ST_CHECK;
          end else begin
            cnt_next = cnt + LEN_W'(1);
          end
        end
      end
      // Range check against base^k
      ST_CHECK: begin
        err_next   = wide || (!huge && ((KMER_W'(dividend_a) >= limit) ||
                                        (KMER_W'(dividend_c) >= limit)));
        cnt_next   = '0;
        sub_next   = '0;
        rem_a_next = '0;
        rem_c_next = '0;
        state_next = err_next ? ST_FINISH : ST_DIGIT;
      end
      // Peel one digit off both k-mers, one chunk per cycle
      ST_DIGIT: begin
        dividend_a_next = (dividend_a << STEP_BITS) | PADW'(chunk_a.quo);
        dividend_c_next = (dividend_c << STEP_BITS) | PADW'(chunk_c.quo);
        rem_a_next      = chunk_a.rem;
        rem_c_next      = chunk_c.rem;
        if (sub == SUB_W'(DIV_CYCLES - 1)) begin
          sub_next   = '0;
          rem_a_next = '0;
          rem_c_next = '0;
          if (chunk_a.rem != chunk_c.rem) begin
            count_next = count + COUNT_W'(1);
          end
          if (cnt == k_eff - LEN_W'(1)) begin
            state_next = ST_FINISH;
          end else begin
            cnt_next = cnt + LEN_W'(1);
          end
        end else begin
          sub_next = sub + SUB_W'(1);
        end
      end
      // Hand the item over once the output register is free
      ST_FINISH: begin
        if (!out_valid || result.ready) begin
          out_valid_next = 1'b1;
          out_count_next = err ? '0 : count;
          out_err_next   = err;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign result.valid          = out_valid;
  assign result.mismatch_count = out_count;
  assign result.range_error    = out_err;

`ifndef ASSERT_OFF
  a_err_zero_count: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.range_error |-> result.mismatch_count == '0)
    else $error("range error with non-zero count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.mismatch_count <= COUNT_W'(k_eff))
    else $error("mismatch count above k-mer length");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIGIT |-> cnt < k_eff)
    else $error("digit counter ran past k-mer length");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    query.valid && query.ready |=> state == ST_LIMIT)
    else $error("accepted item did not start the limit loop");
`endif

endmodule

/* tb/sv/tb_kmer_mismatch_count_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kmer_mismatch_count_top
// Self-checking bench for the k-mer mismatch counter. Pairs of k-mers go in
// through a queue-fed driver and are scored by an in-bench predictor of the
// digit-wise Hamming distance and range check. Results are compared in order
// under a sweep of length and base settings and varied handshake pressure.
// ----------------------------------------------------------------------------
module tb_kmer_mismatch_count_top;
  import kmc_pkg::*;

  localparam int MAX_DIGITS     = 32;
  localparam int VALUE_BITS     = 64;
  localparam int NUM_PHASES     = 17;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 50;

  typedef struct packed {
    logic [KMER_W-1:0] kmer_a;
    logic [KMER_W-1:0] kmer_b;
  } kmer_pair_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               range_err;
  } kmer_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  kmc_in_if  query_ch ();
  kmc_out_if result_ch ();

  kmer_mismatch_count_top #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .query     (query_ch),
    .result    (result_ch)
  );

  // Shadow copy of the configuration registers
  logic [LEN_W-1:0]  len_shadow;
  logic [BASE_W-1:0] base_shadow;

  kmer_pair_t   query_backlog[$];
  kmer_result_t expected_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned idle_cycles;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned clamp_length(logic [LEN_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > MAX_DIGITS) return MAX_DIGITS;
    return 32'(raw);
  endfunction

  function automatic int unsigned clamp_base(logic [BASE_W-1:0] raw);
    if (raw < BASE_MIN) return 32'(BASE_MIN);
    if (raw > BASE_MAX) return 32'(BASE_MAX);
    return 32'(raw);
  endfunction

  // base^k; the top bit flags a power that does not fit in 64 bits
  function automatic logic [64:0] kmer_limit(int unsigned k, int unsigned b);
    logic [63:0] lim;
    logic [68:0] prod;
    logic        huge;
    lim  = 64'd1;
    huge = 1'b0;
    for (int unsigned i = 0; i < k; i++) begin
      if (!huge) begin
        prod = 69'(lim) * 69'(b);
        if (prod[68:64] != '0) huge = 1'b1;
        else lim = prod[63:0];
      end
    end
    return {huge, lim};
  endfunction

  function automatic logic wider_than_value(logic [KMER_W-1:0] v);
    if (VALUE_BITS >= KMER_W) return 1'b0;
    return (v >> VALUE_BITS) != '0;
  endfunction

  function automatic kmer_result_t predict_mismatch(logic [KMER_W-1:0] a,
                                                    logic [KMER_W-1:0] c);
    int unsigned  k;
    int unsigned  b;
    logic [64:0]  lim;
    kmer_result_t res;
    k   = clamp_length(len_shadow);
    b   = clamp_base(base_shadow);
    lim = kmer_limit(k, b);
    res.count     = '0;
    res.range_err = wider_than_value(a) || wider_than_value(c);
    if (!lim[64] && (a >= lim[63:0] || c >= lim[63:0])) res.range_err = 1'b1;
    if (!res.range_err) begin
      for (int unsigned i = 0; i < k; i++) begin
        if ((a % 64'(b)) != (c % 64'(b))) res.count++;
        a = a / 64'(b);
        c = c / 64'(b);
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic kmer_pair_t random_pair(int unsigned k, int unsigned b);
    logic [64:0] lim;
    logic [63:0] edge_val;
    logic [63:0] weight;
    kmer_pair_t  p;
    int unsigned da;
    int unsigned db;
    int unsigned sel;
    int unsigned flip_pct;
    lim      = kmer_limit(k, b);
    edge_val = lim[64] ? 64'hFFFF_FFFF_FFFF_FFFF : lim[63:0];
    sel      = $urandom_range(99);
    if (sel < 70) begin
      // well-formed pair: random digits, a random share of them altered
      flip_pct = $urandom_range(100);
      p        = '0;
      weight   = 64'd1;
      for (int unsigned i = 0; i < k; i++) begin
        da = $urandom_range(b - 1);
        db = da;
        if ($urandom_range(99) < flip_pct) db = (da + $urandom_range(b - 1, 1)) % b;
        p.kmer_a = p.kmer_a + 64'(da) * weight;
        p.kmer_b = p.kmer_b + 64'(db) * weight;
        weight   = weight * 64'(b);
      end
    end else if (sel < 80) begin
      // straddle the range limit
      p.kmer_a = edge_val - 64'($urandom_range(1));
      p.kmer_b = $urandom_range(1) ? edge_val - 64'($urandom_range(1)) : 64'd0;
      if ($urandom_range(1)) p = {p.kmer_b, p.kmer_a};
    end else begin
      // noise of random width
      p.kmer_a = {$urandom, $urandom} >> $urandom_range(63);
      p.kmer_b = {$urandom, $urandom} >> $urandom_range(63);
    end
    return p;
  endfunction

  task automatic queue_pair(input logic [KMER_W-1:0] a, input logic [KMER_W-1:0] c);
    kmer_pair_t p;
    p.kmer_a      = a;
    p.kmer_b      = c;
    query_backlog = {query_backlog, p};
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_KMER_LENGTH) len_shadow = data[LEN_W-1:0];
    else base_shadow = data[BASE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until nothing is pending or in flight
  task automatic wait_drained;
    do @(negedge clk);
    while (query_backlog.size() != 0 || query_ch.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // {length data, base data} written at the start of each phase after the first
  function automatic logic [11:0] phase_setting(int p);
    case (p)
      1:  return {6'd1,  6'd2};
      2:  return {6'd32, 6'd16};
      3:  return {6'd32, 6'd2};
      4:  return {6'd0,  6'd0};
      5:  return {6'd63, 6'd31};
      6:  return {6'd8,  6'd1};
      7:  return {6'd5,  6'd17};
      8:  return {6'd16, 6'd16};
      9:  return {6'd15, 6'd16};
      10: return {6'd12, 6'd3};
      11: return {6'd32, 6'd3};
      12: return {6'd6,  6'd10};
      13: return {6'd3,  6'd63};
      14: return {6'd20, 6'd7};
      15: return {6'd40, 6'd5};
      16: return {6'd10, 6'd48};
      default: return {6'd4, 6'd4};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Query driver: take the next item from the backlog when the slot is free
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_query
    kmer_pair_t next_pair;
    if (rst) begin
      query_ch.valid <= 1'b0;
    end else begin
      if (query_ch.valid && query_ch.ready) begin
        expected_results = {expected_results,
                            predict_mismatch(query_ch.first_kmer,
                                             query_ch.second_kmer)};
      end
      if (!query_ch.valid || query_ch.ready) begin
        if (query_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pair = query_backlog.pop_front();
          query_ch.valid       <= 1'b1;
          query_ch.first_kmer  <= next_pair.kmer_a;
          query_ch.second_kmer <= next_pair.kmer_b;
        end else begin
          query_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each item against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    kmer_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("result with nothing expected: count %0d, range_error %0b",
                                 result_ch.mismatch_count, result_ch.range_error));
        end else begin
          want = expected_results.pop_front();
          if (result_ch.mismatch_count !== want.count)
            report_error($sformatf("mismatch_count: got %0d, expected %0d",
                                   result_ch.mismatch_count, want.count));
          if (result_ch.range_error !== want.range_err)
            report_error($sformatf("range_error: got %0b, expected %0b",
                                   result_ch.range_error, want.range_err));
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no item moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** kmer_mismatch_count_top: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed items, then one random phase per setting
  // --------------------------------------------------------------------------
  initial begin
    int unsigned k;
    int unsigned b;
    int unsigned per_phase;
    logic [11:0] setting;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    len_shadow           = KMER_LENGTH_RST;
    base_shadow          = ALPHABET_BASE_RST;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    error_count          = 0;
    per_phase            = RANDOM_ITEMS / NUM_PHASES;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed items at the reset setting: four base-4 digits, limit 256
    queue_pair(64'd0, 64'd0);
    queue_pair(64'd255, 64'd255);
    queue_pair(64'd255, 64'd0);
    queue_pair(64'd0, 64'd255);
    queue_pair(64'h1B, 64'hE4);
    queue_pair(64'h1B, 64'h1F);
    queue_pair(64'd256, 64'd0);
    queue_pair(64'd0, 64'd256);
    queue_pair(64'd256, 64'd256);
    queue_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    queue_pair(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_pair(64'h8000_0000_0000_0000, 64'd1);
    queue_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p > 0) begin
        setting = phase_setting(p);
        write_reg(CFG_KMER_LENGTH, setting[11:6]);
        write_reg(CFG_ALPHABET_BASE, setting[5:0]);
        @(negedge clk);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      k = clamp_length(len_shadow);
      b = clamp_base(base_shadow);
      for (int unsigned i = 0; i < per_phase / 2; i++)
        query_backlog = {query_backlog, random_pair(k, b)};
      // hold the sender until the block has emptied
      wait_drained();
      for (int unsigned i = per_phase / 2; i < per_phase; i++)
        query_backlog = {query_backlog, random_pair(k, b)};
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d expected results never came", expected_results.size()));
    if (error_count == 0) begin
      $display("** kmer_mismatch_count_top: PASSED **");
    end else begin
      $display("** kmer_mismatch_count_top: FAILED **");
    end
    $finish;
  end

endmodule

/* kmer_mismatch_count_top.f */
hw/rtl/kmc_pkg.sv
hw/rtl/kmc_if.sv
hw/rtl/kmer_mismatch_count_top.sv
tb/sv/tb_kmer_mismatch_count_top.sv
